// ===== design/mrc_pkg.sv =====
// shared types, constants and register indexes of the modbus rtu request checker
package mrc_pkg;

	localparam int MAX_FRAME_BYTES_DEFAULT = 511;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_READ_BITS    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WRITE_BITS   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WRITE_WORDS  = 8'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_READ_BITS   = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_READ_WORDS  = 8'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_WRITE_BITS  = 8'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_WRITE_WORDS = 8'd7;

	typedef enum logic [2:0] {
		VERDICT_OK       = 3'd0,
		VERDICT_ADDR     = 3'd1,
		VERDICT_CRC      = 3'd2,
		VERDICT_FUNCTION = 3'd3,
		VERDICT_LENGTH   = 3'd4
	} verdict_t;

	typedef struct packed {
		logic [7:0]  slave_address;
		logic [15:0] max_read_bits;
		logic [15:0] max_write_bits;
		logic [15:0] max_write_words;
		logic [7:0]  code_read_bits;
		logic [7:0]  code_read_words;
		logic [7:0]  code_write_bits;
		logic [7:0]  code_write_words;
	} cfg_t;

	// header fields and crc status of a finished frame
	typedef struct packed {
		logic [7:0]  address_byte;
		logic [7:0]  function_byte;
		logic [15:0] start_field;
		logic [15:0] quantity_field;
		logic [7:0]  byte_count_field;
		logic        crc_ok;
	} snap_t;

endpackage

// ===== design/mrc_if.sv =====
// request, result and configuration channel interfaces
interface mrc_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_end;

	modport source (output valid, output rx_byte, output frame_end, input ready);
	modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrc_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [7:0]  function_code;
	logic [15:0] start_address;
	logic [15:0] quantity;

	modport source (output valid, output verdict, output function_code,
		output start_address, output quantity, input ready);
	modport sink (input valid, input verdict, input function_code,
		input start_address, input quantity, output ready);
endinterface

interface mrc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mrc_pkg::CFG_IDX_W-1:0]  index;
	logic [mrc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/mrc_cfg_regs.sv =====
// configuration register file of the request checker
module mrc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [mrc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [mrc_pkg::CFG_DATA_W-1:0] wr_data,
	output mrc_pkg::cfg_t                  cfg
);

	mrc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address    <= 8'd1;
			cfg_q.max_read_bits    <= 16'd2000;
			cfg_q.max_write_bits   <= 16'd1968;
			cfg_q.max_write_words  <= 16'd123;
			cfg_q.code_read_bits   <= 8'd2;
			cfg_q.code_read_words  <= 8'd4;
			cfg_q.code_write_bits  <= 8'd15;
			cfg_q.code_write_words <= 8'd16;
		end else if (wr_en) begin
			unique case (wr_index)
				mrc_pkg::CFG_SLAVE_ADDRESS:    cfg_q.slave_address    <= wr_data[7:0];
				mrc_pkg::CFG_MAX_READ_BITS:    cfg_q.max_read_bits    <= wr_data;
				mrc_pkg::CFG_MAX_WRITE_BITS:   cfg_q.max_write_bits   <= wr_data;
				mrc_pkg::CFG_MAX_WRITE_WORDS:  cfg_q.max_write_words  <= wr_data;
				mrc_pkg::CFG_CODE_READ_BITS:   cfg_q.code_read_bits   <= wr_data[7:0];
				mrc_pkg::CFG_CODE_READ_WORDS:  cfg_q.code_read_words  <= wr_data[7:0];
				mrc_pkg::CFG_CODE_WRITE_BITS:  cfg_q.code_write_bits  <= wr_data[7:0];
				mrc_pkg::CFG_CODE_WRITE_WORDS: cfg_q.code_write_words <= wr_data[7:0];
				default: ; // unmapped index, ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/mrc_frame_tracker.sv =====
// per-frame crc, byte counter and header capture, snapshot at frame end
module mrc_frame_tracker #(
	parameter int MAX_FRAME_BYTES = mrc_pkg::MAX_FRAME_BYTES_DEFAULT,
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [7:0]       rx_byte,
	input  logic             frame_end,
	output mrc_pkg::snap_t   snap_s2,
	output logic [CNT_W-1:0] len_s2
);

	logic [15:0]      crc_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       address_q;
	logic [7:0]       function_q;
	logic [15:0]      start_q;
	logic [15:0]      quantity_q;
	logic [7:0]       byte_count_q;

	logic [15:0]      crc_next;
	logic [CNT_W-1:0] count_next;
	logic [7:0]       address_next;
	logic [7:0]       function_next;
	logic [15:0]      start_next;
	logic [15:0]      quantity_next;
	logic [7:0]       byte_count_next;

	// byte-wide reflected crc update, unrolled over the eight bits
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ mrc_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	always_comb begin
		crc_next        = crc_update(crc_q, rx_byte);
		count_next      = (count_q < CNT_W'(MAX_FRAME_BYTES)) ? CNT_W'(count_q + 1'b1) : count_q;
		address_next    = address_q;
		function_next   = function_q;
		start_next      = start_q;
		quantity_next   = quantity_q;
		byte_count_next = byte_count_q;
		case (count_q)
			CNT_W'(0): address_next          = rx_byte;
			CNT_W'(1): function_next         = rx_byte;
			CNT_W'(2): start_next[15:8]      = rx_byte;
			CNT_W'(3): start_next[7:0]       = rx_byte;
			CNT_W'(4): quantity_next[15:8]   = rx_byte;
			CNT_W'(5): quantity_next[7:0]    = rx_byte;
			CNT_W'(6): byte_count_next       = rx_byte;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= mrc_pkg::CRC_INIT;
			count_q      <= '0;
			address_q    <= '0;
			function_q   <= '0;
			start_q      <= '0;
			quantity_q   <= '0;
			byte_count_q <= '0;
		end else if (go) begin
			if (frame_end) begin
				crc_q        <= mrc_pkg::CRC_INIT;
				count_q      <= '0;
				address_q    <= '0;
				function_q   <= '0;
				start_q      <= '0;
				quantity_q   <= '0;
				byte_count_q <= '0;
			end else begin
				crc_q        <= crc_next;
				count_q      <= count_next;
				address_q    <= address_next;
				function_q   <= function_next;
				start_q      <= start_next;
				quantity_q   <= quantity_next;
				byte_count_q <= byte_count_next;
			end
		end
	end

	// snapshot of the finished frame
	always_ff @(posedge clk) begin
		if (go && frame_end) begin
			snap_s2.address_byte     <= address_next;
			snap_s2.function_byte    <= function_next;
			snap_s2.start_field      <= start_next;
			snap_s2.quantity_field   <= quantity_next;
			snap_s2.byte_count_field <= byte_count_next;
			snap_s2.crc_ok           <= (crc_next == 16'h0000);
			len_s2                   <= count_next;
		end
	end

	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		go && frame_end |=> count_q == '0 && crc_q == mrc_pkg::CRC_INIT)
		else $error("frame state not cleared after frame end");

endmodule

// ===== design/mrc_judge.sv =====
// verdict logic and result register
module mrc_judge #(
	parameter int MAX_FRAME_BYTES = mrc_pkg::MAX_FRAME_BYTES_DEFAULT,
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1)
) (
	input  logic               clk,
	input  logic               load,
	input  mrc_pkg::cfg_t      cfg,
	input  mrc_pkg::snap_t     snap,
	input  logic [CNT_W-1:0]   len,
	output mrc_pkg::verdict_t  verdict_q,
	output logic [7:0]         function_code_q,
	output logic [15:0]        start_address_q,
	output logic [15:0]        quantity_q
);

	mrc_pkg::verdict_t verdict;
	logic        at_ceiling;
	logic        len_eq8;
	logic        q_zero;
	logic        over_room;
	logic [16:0] end_addr;
	logic [17:0] len_ext;
	logic [16:0] bits_bytes;
	logic [16:0] twice_q;
	logic        rb_bad;
	logic        rw_bad;
	logic        wb_bad;
	logic        ww_bad;

	always_comb begin
		at_ceiling = len >= CNT_W'(MAX_FRAME_BYTES);
		len_eq8    = len == CNT_W'(8);
		q_zero     = snap.quantity_field == 16'd0;
		end_addr   = {1'b0, snap.quantity_field} + {1'b0, snap.start_field};
		// quantity beyond the top of the address space
		over_room  = end_addr > 17'h10000;
		len_ext    = 18'(len);
		bits_bytes = ({1'b0, snap.quantity_field} + 17'd7) >> 3;
		twice_q    = {snap.quantity_field, 1'b0};

		rb_bad = at_ceiling || !len_eq8 || q_zero || over_room ||
			snap.quantity_field > cfg.max_read_bits;
		rw_bad = at_ceiling || !len_eq8 || q_zero || over_room;
		wb_bad = at_ceiling || q_zero ||
			len_ext != (18'(snap.byte_count_field) + 18'd9) ||
			snap.quantity_field > cfg.max_write_bits ||
			17'(snap.byte_count_field) != bits_bytes;
		ww_bad = at_ceiling || q_zero ||
			len_ext != (18'(twice_q) + 18'd9) ||
			snap.quantity_field > cfg.max_write_words ||
			17'(snap.byte_count_field) != twice_q;

		if (snap.address_byte != cfg.slave_address) begin
			verdict = mrc_pkg::VERDICT_ADDR;
		end else if (len < CNT_W'(4) || !snap.crc_ok) begin
			verdict = mrc_pkg::VERDICT_CRC;
		end else if (snap.function_byte == cfg.code_read_bits) begin
			verdict = rb_bad ? mrc_pkg::VERDICT_LENGTH : mrc_pkg::VERDICT_OK;
		end else if (snap.function_byte == cfg.code_read_words) begin
			verdict = rw_bad ? mrc_pkg::VERDICT_LENGTH : mrc_pkg::VERDICT_OK;
		end else if (snap.function_byte == cfg.code_write_bits) begin
			verdict = wb_bad ? mrc_pkg::VERDICT_LENGTH : mrc_pkg::VERDICT_OK;
		end else if (snap.function_byte == cfg.code_write_words) begin
			verdict = ww_bad ? mrc_pkg::VERDICT_LENGTH : mrc_pkg::VERDICT_OK;
		end else begin
			verdict = mrc_pkg::VERDICT_FUNCTION;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict_q       <= verdict;
			function_code_q <= snap.function_byte;
			start_address_q <= snap.start_field;
			quantity_q      <= snap.quantity_field;
		end
	end

endmodule

// ===== design/modbus_rtu_request_checker.sv =====
// top level of the modbus rtu request checker
//
//   channel  dir  payload                                        moves
//   req      in   rx_byte[7:0], frame_end                        one frame byte per request
//   res      out  verdict[2:0], function_code, start_address,    one verdict per frame
//                 quantity
//   cfg      in   index[7:0], data[15:0]                         one register write
//
// one request a cycle sustained; the byte-wide crc update and header capture
// sit between the input register and the frame snapshot, the verdict logic
// between the snapshot and the result register
// a verdict moves from the input register through the snapshot into the result register
// reset clears the frame state and loads the register defaults; no clearing pass
// a stalled result only holds back a further frame-end byte: mid-frame bytes
// keep flowing, up to three verdicts can be in flight
module modbus_rtu_request_checker #(
	parameter int MAX_FRAME_BYTES = mrc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
	input logic      clk,
	input logic      arst_n,
	mrc_req_if.sink  req,
	mrc_res_if.source res,
	mrc_cfg_if.sink  cfg
);

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

	mrc_pkg::cfg_t     cfg_regs;
	mrc_pkg::snap_t    snap_s2;
	logic [CNT_W-1:0]  len_s2;
	mrc_pkg::verdict_t verdict_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// snapshot and result valid flags
	logic valid_s2;
	logic res_valid_q;

	logic advance_out;
	logic s2_free;
	logic go;
	logic load_s1;
	logic out_load;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	mrc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	// flow control: only a frame-end byte needs a free snapshot slot
	assign advance_out = !res_valid_q || res.ready;
	assign s2_free     = !valid_s2 || advance_out;
	assign go          = valid_s1 && (!last_s1 || s2_free);
	assign req.ready   = !valid_s1 || go;
	assign load_s1     = req.valid && req.ready;
	assign out_load    = valid_s2 && advance_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= req.rx_byte;
			last_s1 <= req.frame_end;
		end
	end

	mrc_frame_tracker #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_frame_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.rx_byte   (byte_s1),
		.frame_end (last_s1),
		.snap_s2   (snap_s2),
		.len_s2    (len_s2)
	);

	// snapshot slot: filled by a frame-end byte, drained into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (advance_out) begin
			valid_s2 <= 1'b0;
		end
	end

	mrc_judge #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_judge (
		.clk             (clk),
		.load            (out_load),
		.cfg             (cfg_regs),
		.snap            (snap_s2),
		.len             (len_s2),
		.verdict_q       (verdict_q),
		.function_code_q (res.function_code),
		.start_address_q (res.start_address),
		.quantity_q      (res.quantity)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.verdict = verdict_q;

	// a held snapshot is never dropped while the result is stalled
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !advance_out |=> valid_s2)
		else $error("snapshot lost under result stall");

	// a frame-end byte that leaves the input register always lands in the snapshot
	a_last_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		go && last_s1 |=> valid_s2)
		else $error("frame-end byte produced no snapshot");

	// back pressure only comes from a waiting frame-end byte
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && last_s1 && valid_s2 && res_valid_q)
		else $error("request stalled without a pending verdict");

endmodule

// ===== bench/tb_modbus_rtu_request_checker.sv =====
// self-checking bench for the modbus rtu request checker: random and directed frames, scoreboard
`timescale 1ns / 1ps

module tb_modbus_rtu_request_checker;

	// no-accept cycles before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;
	// settling pause once every awaited verdict has come out
	localparam int LATENCY_PAUSE  = 8;
	// random requests per configuration phase
	localparam int PHASE_REQUESTS = 230;
	localparam int PHASES         = 6;

	// one verdict as seen on the result channel
	typedef struct packed {
		logic [2:0]  verdict;
		logic [7:0]  function_code;
		logic [15:0] start_address;
		logic [15:0] quantity;
	} verdict_rec_t;

	// predicts verdicts from accepted requests and matches them against results
	class frame_scoreboard;
		mrc_pkg::cfg_t regs;
		logic [15:0]   crc;
		int unsigned   byte_count;
		logic [7:0]    addr_seen;
		logic [7:0]    func_seen;
		logic [7:0]    bc_seen;
		logic [15:0]   start_seen;
		logic [15:0]   qty_seen;
		verdict_rec_t  awaited[$];
		int            errors;

		function new();
			regs.slave_address    = 8'd1;
			regs.max_read_bits    = 16'd2000;
			regs.max_write_bits   = 16'd1968;
			regs.max_write_words  = 16'd123;
			regs.code_read_bits   = 8'd2;
			regs.code_read_words  = 8'd4;
			regs.code_write_bits  = 8'd15;
			regs.code_write_words = 8'd16;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			crc        = mrc_pkg::CRC_INIT;
			byte_count = 0;
			addr_seen  = 8'h00;
			func_seen  = 8'h00;
			bc_seen    = 8'h00;
			start_seen = 16'h0000;
			qty_seen   = 16'h0000;
		endfunction

		// reflected crc-16, one byte
		static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {8'h00, b};
			for (int i = 0; i < 8; i++)
				r = r[0] ? ((r >> 1) ^ mrc_pkg::CRC_POLY) : (r >> 1);
			return r;
		endfunction

		function void set_reg(logic [7:0] idx, logic [15:0] d);
			case (idx)
				mrc_pkg::CFG_SLAVE_ADDRESS:    regs.slave_address    = d[7:0];
				mrc_pkg::CFG_MAX_READ_BITS:    regs.max_read_bits    = d;
				mrc_pkg::CFG_MAX_WRITE_BITS:   regs.max_write_bits   = d;
				mrc_pkg::CFG_MAX_WRITE_WORDS:  regs.max_write_words  = d;
				mrc_pkg::CFG_CODE_READ_BITS:   regs.code_read_bits   = d[7:0];
				mrc_pkg::CFG_CODE_READ_WORDS:  regs.code_read_words  = d[7:0];
				mrc_pkg::CFG_CODE_WRITE_BITS:  regs.code_write_bits  = d[7:0];
				mrc_pkg::CFG_CODE_WRITE_WORDS: regs.code_write_words = d[7:0];
				default: ;
			endcase
		endfunction

		// address, then crc, then function, then length and quantity
		function mrc_pkg::verdict_t judge(int unsigned len);
			int unsigned q;
			int unsigned room;
			int unsigned bc;
			bit          at_ceiling;
			q          = qty_seen;
			bc         = bc_seen;
			room       = 32'h10000 - int'(start_seen);
			at_ceiling = len >= mrc_pkg::MAX_FRAME_BYTES_DEFAULT;
			if (addr_seen != regs.slave_address)
				return mrc_pkg::VERDICT_ADDR;
			if (len < 4 || crc != 16'h0000)
				return mrc_pkg::VERDICT_CRC;
			if (func_seen == regs.code_read_bits) begin
				if (at_ceiling || len != 8 || q < 1 || q > regs.max_read_bits || q > room)
					return mrc_pkg::VERDICT_LENGTH;
				return mrc_pkg::VERDICT_OK;
			end
			if (func_seen == regs.code_read_words) begin
				if (at_ceiling || len != 8 || q < 1 || q > room)
					return mrc_pkg::VERDICT_LENGTH;
				return mrc_pkg::VERDICT_OK;
			end
			if (func_seen == regs.code_write_bits) begin
				if (at_ceiling || len != bc + 9 || q < 1 || q > regs.max_write_bits ||
						bc != (q + 7) / 8)
					return mrc_pkg::VERDICT_LENGTH;
				return mrc_pkg::VERDICT_OK;
			end
			if (func_seen == regs.code_write_words) begin
				if (at_ceiling || len != 2 * q + 9 || q < 1 || q > regs.max_write_words ||
						bc != 2 * q)
					return mrc_pkg::VERDICT_LENGTH;
				return mrc_pkg::VERDICT_OK;
			end
			return mrc_pkg::VERDICT_FUNCTION;
		endfunction

		function void note_request(logic [7:0] b, logic last);
			verdict_rec_t e;
			case (byte_count)
				0: addr_seen = b;
				1: func_seen = b;
				2: start_seen[15:8] = b;
				3: start_seen[7:0] = b;
				4: qty_seen[15:8] = b;
				5: qty_seen[7:0] = b;
				6: bc_seen = b;
				default: ;
			endcase
			crc = crc_next(crc, b);
			if (byte_count < mrc_pkg::MAX_FRAME_BYTES_DEFAULT)
				byte_count++;
			if (last) begin
				e.verdict       = judge(byte_count);
				e.function_code = func_seen;
				e.start_address = start_seen;
				e.quantity      = qty_seen;
				awaited.push_back(e);
				clear_frame();
			end
		endfunction

		task report(string what);
			$display("ERROR: %s", what);
			errors++;
		endtask

		task check_verdict(verdict_rec_t got);
			verdict_rec_t want;
			if (awaited.size() == 0) begin
				report($sformatf("verdict %0d (fc %h) with no frame waiting",
					got.verdict, got.function_code));
				return;
			end
			want = awaited.pop_front();
			if (got.verdict != want.verdict)
				report($sformatf("verdict %0d, expected %0d (fc %h)",
					got.verdict, want.verdict, want.function_code));
			if (got.function_code != want.function_code)
				report($sformatf("function_code %h, expected %h",
					got.function_code, want.function_code));
			if (got.start_address != want.start_address)
				report($sformatf("start_address %h, expected %h",
					got.start_address, want.start_address));
			if (got.quantity != want.quantity)
				report($sformatf("quantity %h, expected %h", got.quantity, want.quantity));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	mrc_req_if req();
	mrc_res_if res();
	mrc_cfg_if cfg();

	modbus_rtu_request_checker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.cfg    (cfg)
	);

	frame_scoreboard sb;
	verdict_rec_t    got_verdict;
	logic [7:0]      frame_bytes[$];
	int              burst_left = 0;
	int              sent = 0;
	int              idle_cycles = 0;
	int              stall_left = 0;
	int              quiet_left = 0;

	// monitor: every handshake of every channel is sampled here, at the edge,
	// so prediction and checking never depend on process order
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_request(req.rx_byte, req.frame_end);
			if (cfg.valid && cfg.ready)
				sb.set_reg(cfg.index, cfg.data);
			if (res.valid && res.ready) begin
				got_verdict.verdict       = res.verdict;
				got_verdict.function_code = res.function_code;
				got_verdict.start_address = res.start_address;
				got_verdict.quantity      = res.quantity;
				sb.check_verdict(got_verdict);
			end
			// watchdog on any kind of progress
			if ((req.valid && req.ready) || (cfg.valid && cfg.ready) ||
					(res.valid && res.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	// receiver: short random stalls, occasional long stalls, and quiet stretches
	// where ready stays high
	initial begin
		int r;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (quiet_left > 0) begin
				quiet_left--;
				res.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 2) begin
					quiet_left = $urandom_range(50, 200);
					res.ready <= 1'b1;
				end else if (r < 6) begin
					stall_left = $urandom_range(4, 24);
					res.ready <= 1'b0;
				end else if (r < 30) begin
					res.ready <= 1'b0;
				end else begin
					res.ready <= 1'b1;
				end
			end
		end
	end

	// one request; the sender runs in bursts with random gaps between them,
	// valid stays high from one request to the next inside a burst
	task automatic send_request(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		req.valid     <= 1'b1;
		req.rx_byte   <= b;
		req.frame_end <= last;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		burst_left--;
		sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++)
			send_request(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// back-to-back writes keep valid high; the caller lowers it afterwards
	task automatic write_reg(input logic [7:0] idx, input logic [15:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	// crc travels low byte first
	function automatic void add_crc();
		logic [15:0] c;
		c = mrc_pkg::CRC_INIT;
		foreach (frame_bytes[i])
			c = frame_scoreboard::crc_next(c, frame_bytes[i]);
		frame_bytes.push_back(c[7:0]);
		frame_bytes.push_back(c[15:8]);
	endfunction

	// mostly legal values, with zero, the limit, one past it and all ones mixed in
	function automatic logic [15:0] pick_quantity(int unsigned maxq, int unsigned cap);
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'(maxq);
			2: return 16'(maxq + 1);
			3: return 16'hFFFF;
			default: return 16'($urandom_range(1, (maxq < cap) ? maxq : cap));
		endcase
	endfunction

	// one random frame: most are well-formed requests with random content,
	// the rest noise, short frames and broken tails
	function automatic void build_frame();
		int unsigned r;
		int unsigned op;
		int unsigned n;
		logic [7:0]  addr;
		logic [7:0]  code;
		logic [7:0]  bc;
		logic [15:0] start;
		logic [15:0] q;
		frame_bytes.delete();
		r = $urandom_range(0, 99);
		addr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : sb.regs.slave_address;
		if (r < 8) begin
			// noise, with or without a good crc
			n = $urandom_range(1, 12);
			frame_bytes.push_back(addr);
			repeat (n - 1) frame_bytes.push_back(8'($urandom));
			if ($urandom_range(0, 1) == 1)
				add_crc();
			return;
		end
		if (r < 12) begin
			// short frame, sometimes just address plus a good crc
			n = $urandom_range(1, 3);
			frame_bytes.push_back(addr);
			if (n == 3 && $urandom_range(0, 1) == 1)
				add_crc();
			else
				repeat (n - 1) frame_bytes.push_back(8'($urandom));
			return;
		end
		op = $urandom_range(0, 9);
		if (op > 4)
			op = op % 4;
		case (op)
			0: code = sb.regs.code_read_bits;
			1: code = sb.regs.code_read_words;
			2: code = sb.regs.code_write_bits;
			3: code = sb.regs.code_write_words;
			default: code = 8'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0: start = 16'h0000;
			1: start = 16'hFFFF;
			default: start = 16'($urandom);
		endcase
		case (op)
			0: q = pick_quantity(sb.regs.max_read_bits, 65535);
			1: q = pick_quantity(2000, 2000);
			2: q = pick_quantity(sb.regs.max_write_bits, 64);
			3: q = pick_quantity(sb.regs.max_write_words, 12);
			default: q = 16'($urandom);
		endcase
		// reads: land on the address-space boundary now and then
		if (op < 2 && $urandom_range(0, 6) == 0)
			start = 16'(32'h10000 - int'(q) + $urandom_range(0, 1));
		frame_bytes.push_back(addr);
		frame_bytes.push_back(code);
		frame_bytes.push_back(start[15:8]);
		frame_bytes.push_back(start[7:0]);
		frame_bytes.push_back(q[15:8]);
		frame_bytes.push_back(q[7:0]);
		if (op == 2 || op == 3) begin
			if (op == 2) begin
				n = (int'(q) + 7) / 8;
				if (n > 32)
					n = $urandom_range(0, 4);
			end else begin
				n = 2 * int'(q);
				if (n > 250 || (n > 24 && $urandom_range(0, 3) != 0))
					n = 2 * $urandom_range(0, 4);
			end
			bc = 8'(n);
			if ($urandom_range(0, 9) == 0)
				bc = 8'($urandom);
			frame_bytes.push_back(bc);
			repeat (n) frame_bytes.push_back(8'($urandom));
		end
		// broken tails: an extra byte, a missing byte, a flipped bit
		r = $urandom_range(0, 19);
		if (r == 0)
			frame_bytes.push_back(8'($urandom));
		else if (r == 1 && frame_bytes.size() > 1)
			void'(frame_bytes.pop_back());
		add_crc();
		if (r == 2) begin
			n = $urandom_range(0, frame_bytes.size() - 1);
			frame_bytes[n] = frame_bytes[n] ^ 8'(1 << $urandom_range(0, 7));
		end
	endfunction

	// frame around the byte counter ceiling, good crc
	function automatic void build_long_frame();
		int unsigned n;
		frame_bytes.delete();
		n = $urandom_range(509, 525);
		frame_bytes.push_back(sb.regs.slave_address);
		frame_bytes.push_back(sb.regs.code_write_bits);
		repeat (n - 4) frame_bytes.push_back(8'($urandom));
		add_crc();
	endfunction

	// let every verdict come out, then give the pipeline time to settle
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (LATENCY_PAUSE) @(posedge clk);
	endtask

	// register settings per phase; phase 0 runs on the reset values
	task automatic configure(input int p);
		case (p)
			1: begin
				// limits of one, standard codes, address zero
				write_reg(mrc_pkg::CFG_SLAVE_ADDRESS, 16'h0000);
				write_reg(mrc_pkg::CFG_MAX_READ_BITS, 16'd1);
				write_reg(mrc_pkg::CFG_MAX_WRITE_BITS, 16'd1);
				write_reg(mrc_pkg::CFG_MAX_WRITE_WORDS, 16'd1);
				write_reg(mrc_pkg::CFG_CODE_READ_BITS, 16'h0001);
				write_reg(mrc_pkg::CFG_CODE_READ_WORDS, 16'h0003);
				write_reg(mrc_pkg::CFG_CODE_WRITE_BITS, 16'h000F);
				write_reg(mrc_pkg::CFG_CODE_WRITE_WORDS, 16'h0010);
			end
			2: begin
				// largest limits, extreme codes, top address
				write_reg(mrc_pkg::CFG_SLAVE_ADDRESS, 16'h00FF);
				write_reg(mrc_pkg::CFG_MAX_READ_BITS, 16'hFFFF);
				write_reg(mrc_pkg::CFG_MAX_WRITE_BITS, 16'hFFFF);
				write_reg(mrc_pkg::CFG_MAX_WRITE_WORDS, 16'hFFFF);
				write_reg(mrc_pkg::CFG_CODE_READ_BITS, 16'h0000);
				write_reg(mrc_pkg::CFG_CODE_READ_WORDS, 16'h00FF);
				write_reg(mrc_pkg::CFG_CODE_WRITE_BITS, 16'h000F);
				write_reg(mrc_pkg::CFG_CODE_WRITE_WORDS, 16'h0010);
			end
			3: begin
				// three codes equal: read bits must win
				write_reg(mrc_pkg::CFG_SLAVE_ADDRESS, 16'h00F7);
				write_reg(mrc_pkg::CFG_MAX_READ_BITS, 16'd300);
				write_reg(mrc_pkg::CFG_CODE_READ_BITS, 16'h0041);
				write_reg(mrc_pkg::CFG_CODE_READ_WORDS, 16'h0041);
				write_reg(mrc_pkg::CFG_CODE_WRITE_BITS, 16'h0041);
				write_reg(mrc_pkg::CFG_CODE_WRITE_WORDS, 16'h0043);
			end
			4: begin
				// random values, junk in the upper data bits and an unused index
				write_reg(mrc_pkg::CFG_SLAVE_ADDRESS, 16'($urandom));
				write_reg(mrc_pkg::CFG_MAX_READ_BITS, 16'($urandom_range(1, 300)));
				write_reg(mrc_pkg::CFG_MAX_WRITE_BITS, 16'($urandom_range(1, 300)));
				write_reg(mrc_pkg::CFG_MAX_WRITE_WORDS, 16'($urandom_range(1, 20)));
				write_reg(mrc_pkg::CFG_CODE_READ_BITS,
					{8'($urandom), 8'($urandom_range(1, 20))});
				write_reg(mrc_pkg::CFG_CODE_READ_WORDS,
					{8'($urandom), 8'($urandom_range(1, 20))});
				write_reg(mrc_pkg::CFG_CODE_WRITE_BITS,
					{8'($urandom), 8'($urandom_range(1, 20))});
				write_reg(mrc_pkg::CFG_CODE_WRITE_WORDS,
					{8'($urandom), 8'($urandom_range(1, 20))});
				write_reg(8'($urandom_range(8, 255)), 16'($urandom));
			end
			default: begin
				// back to reset limits; later codes shadowed by read words
				write_reg(mrc_pkg::CFG_SLAVE_ADDRESS, 16'h0001);
				write_reg(mrc_pkg::CFG_MAX_READ_BITS, 16'd2000);
				write_reg(mrc_pkg::CFG_MAX_WRITE_BITS, 16'd1968);
				write_reg(mrc_pkg::CFG_MAX_WRITE_WORDS, 16'd123);
				write_reg(mrc_pkg::CFG_CODE_READ_BITS, 16'h0001);
				write_reg(mrc_pkg::CFG_CODE_READ_WORDS, 16'h0006);
				write_reg(mrc_pkg::CFG_CODE_WRITE_BITS, 16'h0006);
				write_reg(mrc_pkg::CFG_CODE_WRITE_WORDS, 16'h0006);
				write_reg(8'hFF, 16'hFFFF);
			end
		endcase
		cfg.valid <= 1'b0;
	endtask

	initial begin
		int phase_start;
		sb = new();
		req.valid     = 1'b0;
		req.rx_byte   = 8'h00;
		req.frame_end = 1'b0;
		cfg.valid     = 1'b0;
		cfg.index     = mrc_pkg::CFG_SLAVE_ADDRESS;
		cfg.data      = 16'h0000;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// read bits at the quantity limit from address zero: ok
		frame_bytes = {sb.regs.slave_address, sb.regs.code_read_bits, 8'h00, 8'h00,
			sb.regs.max_read_bits[15:8], sb.regs.max_read_bits[7:0]};
		add_crc();
		send_frame();
		// one-byte frame to our address: short frame is a crc error
		frame_bytes = {sb.regs.slave_address};
		send_frame();
		// address plus a good crc, zero residue but still too short
		frame_bytes = {sb.regs.slave_address};
		add_crc();
		send_frame();
		// unsupported function, the quantity is not in the frame and comes back as zero
		frame_bytes = {sb.regs.slave_address, 8'hFF};
		add_crc();
		send_frame();
		// write bits at the top of the address space, one data byte: ok
		frame_bytes = {sb.regs.slave_address, sb.regs.code_write_bits, 8'hFF, 8'hFF,
			8'h00, 8'h08, 8'h01, 8'hA5};
		add_crc();
		send_frame();
		// wrong address wins over everything
		frame_bytes = {8'h00};
		send_frame();
		drain();

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0)
				configure(p);
			// counter ceiling under the widest limits
			if (p == 2) begin
				build_long_frame();
				send_frame();
			end
			phase_start = sent;
			while (sent - phase_start < PHASE_REQUESTS) begin
				build_frame();
				send_frame();
			end
			drain();
		end

		if (sb.awaited.size() != 0)
			sb.report($sformatf("%0d verdicts never arrived", sb.awaited.size()));
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
